/* rtl/core/swpd_pkg.sv */
// Shared types, constants and helpers for the sync word packet deframer.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package swpd_pkg;

  // Sync word length in bytes (1 to 4).
  localparam int unsigned SYNC_LEN = 4;
  localparam int unsigned SyncBits = 8 * SYNC_LEN;
  localparam int unsigned FillW    = $clog2(SYNC_LEN + 1);

  // Bytes in one course point: x (2), y (2), point type (1).
  localparam int unsigned PointBytes = 5;
  // Number of raw fields in a config packet.
  localparam int unsigned CfgFields  = 6;
  // Entries in the queue between parser and output stage.
  localparam int unsigned QDepth     = 2;

  // Result kinds.
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_POINT   = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_CFG_FLD = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SYNC_WORD = 3'd0;
  localparam logic [2:0] REG_ACK_CODE  = 3'd1;
  localparam logic [2:0] REG_CMD_CODE  = 3'd2;
  localparam logic [2:0] REG_CRS_CODE  = 3'd3;
  localparam logic [2:0] REG_SET_CODE  = 3'd4;
  localparam logic [2:0] REG_MSB_FIRST = 3'd5;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [7:0]  ack_code;
    logic [7:0]  command_code_value;
    logic [7:0]  course_code;
    logic [7:0]  settings_code;
    logic        msb_first;
  } cfg_t;

  // One parsed result, bytes still in arrival order (first byte most significant).
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  index;
    logic [63:0] word;
    logic [7:0]  count;
    logic [3:0]  nbytes;
    logic        last;
  } rec_t;

  // Byte size of config field n; numbers past the end use the final size.
  function automatic logic [3:0] cfg_size(input logic [7:0] n);
    logic [3:0] s;
    case (n)
      8'd0:    s = 4'd8;
      8'd1:    s = 4'd8;
      8'd2:    s = 4'd4;
      8'd3:    s = 4'd8;
      8'd4:    s = 4'd1;
      default: s = 4'd1;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/sync_word_packet_deframer.sv */
// Sync word packet deframer, top level: config registers, parser, queue, output.
// Depends on swpd_pkg, swpd_front, swpd_fifo and swpd_back.
//
// Usage:
//   Input channel: one received byte per beat on rx_byte_i (in_valid_i/in_ready_o).
//   Output channel: one result per beat (out_valid_o/out_ready_i) with kind,
//   field index, raw word, point fields, point count and a last flag that
//   marks the final result of a packet.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_index_i (sync
//   word, four type codes, byte order); write only while idle.
// Timing:
//   One byte per cycle sustained while the queue has room. A byte that
//   completes a result passes through the queue and then the output register
//   before it shows. The parser classifies every byte combinationally.
// Reset:
//   Parser returns to the sync hunt with an empty window, the queue and output
//   register empty; config registers take their defaults (sync word 0,
//   codes 0/1/2/3, most significant byte first).
// Stall:
//   A stalled receiver holds the output beat; results collect in a two-entry
//   queue and in_ready_o drops only when that queue is full.
module sync_word_packet_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [7:0]         field_index_o,
  output logic [63:0]        raw_word_o,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [7:0]         point_kind_o,
  output logic [7:0]         point_count_o,
  output logic               last_o
);

  swpd_pkg::cfg_t cfg_q;
  swpd_pkg::rec_t push_rec, pop_rec;
  logic           push, pop, q_full, q_valid, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word          <= 32'd0;
      cfg_q.ack_code           <= 8'd0;
      cfg_q.command_code_value <= 8'd1;
      cfg_q.course_code        <= 8'd2;
      cfg_q.settings_code      <= 8'd3;
      cfg_q.msb_first          <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        swpd_pkg::REG_SYNC_WORD: cfg_q.sync_word          <= cfg_data_i;
        swpd_pkg::REG_ACK_CODE:  cfg_q.ack_code           <= cfg_data_i[7:0];
        swpd_pkg::REG_CMD_CODE:  cfg_q.command_code_value <= cfg_data_i[7:0];
        swpd_pkg::REG_CRS_CODE:  cfg_q.course_code        <= cfg_data_i[7:0];
        swpd_pkg::REG_SET_CODE:  cfg_q.settings_code      <= cfg_data_i[7:0];
        swpd_pkg::REG_MSB_FIRST: cfg_q.msb_first          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  swpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  swpd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_rec_o  (pop_rec)
  );

  swpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .msb_first_i   (cfg_q.msb_first),
    .q_valid_i     (q_valid),
    .q_rec_i       (pop_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .field_index_o (field_index_o),
    .raw_word_o    (raw_word_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_kind_o  (point_kind_o),
    .point_count_o (point_count_o),
    .last_o        (last_o)
  );

endmodule

/* rtl/core/swpd_front.sv */
// Parser front end: sync hunt, header decode and field assembly.
// Depends on swpd_pkg; pushes one rec_t per result into the queue.
module swpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swpd_pkg::cfg_t     cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output swpd_pkg::rec_t     rec_o
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_SEQ    = 3'd2;
  localparam logic [2:0] PH_CMD    = 3'd3;
  localparam logic [2:0] PH_LEN    = 3'd4;
  localparam logic [2:0] PH_POINTS = 3'd5;
  localparam logic [2:0] PH_CONFIG = 3'd6;

  logic [2:0]                   phase_q, phase_d;
  logic [swpd_pkg::SyncBits-1:0] window_q, window_d;
  logic [swpd_pkg::FillW-1:0]   fill_q, fill_d;
  logic [3:0]                   cnt_q, cnt_d;
  logic [7:0]                   fieldn_q, fieldn_d;
  logic [7:0]                   total_q, total_d;
  logic [63:0]                  asm_q, asm_d;
  logic [7:0]                   type_q, type_d;

  logic [63:0] asm_nx;
  logic [3:0]  cnt_nx;
  logic [3:0]  fsize;
  logic        pt_last;

  assign asm_nx  = {asm_q[55:0], rx_byte_i};
  assign cnt_nx  = cnt_q + 4'd1;
  assign fsize   = swpd_pkg::cfg_size(fieldn_q);
  assign pt_last = (fieldn_q == (total_q - 8'd1));

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    fieldn_d = fieldn_q;
    total_d  = total_q;
    asm_d    = asm_q;
    type_d   = type_q;
    push_o   = 1'b0;
    rec_o    = '0;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          window_d = swpd_pkg::SyncBits'({window_q, rx_byte_i});
          if (fill_q < swpd_pkg::FillW'(swpd_pkg::SYNC_LEN)) begin
            fill_d = fill_q + 1'b1;
          end
          if (fill_d == swpd_pkg::FillW'(swpd_pkg::SYNC_LEN) &&
              window_d == cfg_i.sync_word[swpd_pkg::SyncBits-1:0]) begin
            window_d = '0;
            fill_d   = '0;
            phase_d  = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_d  = rx_byte_i;
          phase_d = PH_SEQ;
        end
        PH_SEQ: begin
          // sequence byte is dropped; dispatch on the latched type
          cnt_d    = '0;
          fieldn_d = '0;
          asm_d    = '0;
          if (type_q == cfg_i.ack_code) begin
            push_o        = 1'b1;
            rec_o.kind    = swpd_pkg::KIND_ACK;
            rec_o.last    = 1'b1;
            phase_d       = PH_HUNT;
          end else if (type_q == cfg_i.command_code_value) begin
            phase_d = PH_CMD;
          end else if (type_q == cfg_i.course_code) begin
            phase_d = PH_LEN;
          end else if (type_q == cfg_i.settings_code) begin
            phase_d = PH_CONFIG;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_CMD: begin
          push_o     = 1'b1;
          rec_o.kind = swpd_pkg::KIND_CMD;
          rec_o.word = {56'd0, rx_byte_i};
          rec_o.last = 1'b1;
          phase_d    = PH_HUNT;
        end
        PH_LEN: begin
          total_d = rx_byte_i;
          if (rx_byte_i == 8'd0) begin
            push_o     = 1'b1;
            rec_o.kind = swpd_pkg::KIND_EMPTY;
            rec_o.last = 1'b1;
            phase_d    = PH_HUNT;
          end else begin
            fieldn_d = '0;
            cnt_d    = '0;
            asm_d    = '0;
            phase_d  = PH_POINTS;
          end
        end
        PH_POINTS: begin
          asm_d = asm_nx;
          cnt_d = cnt_nx;
          if (cnt_nx >= 4'(swpd_pkg::PointBytes)) begin
            push_o       = 1'b1;
            rec_o.kind   = swpd_pkg::KIND_POINT;
            rec_o.index  = fieldn_q;
            rec_o.word   = asm_nx;
            rec_o.count  = total_q;
            rec_o.nbytes = 4'd2;
            rec_o.last   = pt_last;
            cnt_d        = '0;
            asm_d        = '0;
            if (pt_last) begin
              phase_d = PH_HUNT;
            end else begin
              fieldn_d = fieldn_q + 8'd1;
            end
          end
        end
        PH_CONFIG: begin
          asm_d = asm_nx;
          cnt_d = cnt_nx;
          if (cnt_nx >= fsize) begin
            push_o       = 1'b1;
            rec_o.kind   = swpd_pkg::KIND_CFG_FLD;
            rec_o.index  = fieldn_q;
            rec_o.word   = asm_nx;
            rec_o.nbytes = fsize;
            rec_o.last   = (fieldn_q >= 8'(swpd_pkg::CfgFields - 1));
            cnt_d        = '0;
            asm_d        = '0;
            if (rec_o.last) begin
              phase_d = PH_HUNT;
            end else begin
              fieldn_d = fieldn_q + 8'd1;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
      if (phase_d == PH_HUNT && phase_q != PH_HUNT) begin
        window_d = '0;
        fill_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      window_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      fieldn_q <= '0;
      total_q  <= '0;
      asm_q    <= '0;
      type_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      fieldn_q <= fieldn_d;
      total_q  <= total_d;
      asm_q    <= asm_d;
      type_q   <= type_d;
    end
  end

  // the final result of a packet always drops back to the hunt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rec_o.last |=> phase_q == PH_HUNT && fill_q == '0)
    else $error("front not back in hunt after last result");

  // only the point and config phases assemble multi-byte fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_POINTS && phase_q != PH_CONFIG) |-> cnt_q == 4'd0)
    else $error("byte count left over outside field assembly");

endmodule

/* rtl/core/swpd_fifo.sv */
// Short queue of parsed results between parser and output stage.
// Depends on swpd_pkg for rec_t and the queue depth.
module swpd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swpd_pkg::rec_t push_rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output swpd_pkg::rec_t pop_rec_o
);

  localparam int unsigned PtrW = (swpd_pkg::QDepth > 1) ? $clog2(swpd_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(swpd_pkg::QDepth + 1);

  swpd_pkg::rec_t entries_q [swpd_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == CntW'(swpd_pkg::QDepth));
  assign valid_o   = (count_q != '0);
  assign pop_rec_o = entries_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(swpd_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

/* rtl/core/swpd_back.sv */
// Output stage: applies byte order and drives the registered result beat.
// Depends on swpd_pkg; pops rec_t entries from swpd_fifo.
module swpd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               msb_first_i,
  input  logic               q_valid_i,
  input  swpd_pkg::rec_t     q_rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [7:0]         field_index_o,
  output logic [63:0]        raw_word_o,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [7:0]         point_kind_o,
  output logic [7:0]         point_count_o,
  output logic               last_o
);

  logic               valid_q;
  logic [2:0]         kind_q;
  logic [7:0]         index_q;
  logic [63:0]        raw_q;
  logic signed [15:0] x_q, y_q;
  logic [7:0]         pkind_q;
  logic [7:0]         count_q;
  logic               last_q;

  logic [63:0] raw_d;
  logic [15:0] x_d, y_d;
  logic [7:0]  pkind_d;

  // Reverse the low n bytes of v (arrival order to least-first value).
  function automatic logic [63:0] rev_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    int unsigned src;
    r = '0;
    for (int unsigned k = 0; k < 8; k++) begin
      src = 32'(n) - 1 - k;
      if (k < 32'(n)) begin
        r[8*k +: 8] = v[8*src[2:0] +: 8];
      end
    end
    return r;
  endfunction

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    raw_d   = '0;
    x_d     = '0;
    y_d     = '0;
    pkind_d = '0;
    case (q_rec_i.kind)
      swpd_pkg::KIND_CMD: begin
        raw_d = q_rec_i.word;
      end
      swpd_pkg::KIND_POINT: begin
        x_d     = q_rec_i.word[39:24];
        y_d     = q_rec_i.word[23:8];
        pkind_d = q_rec_i.word[7:0];
        if (!msb_first_i) begin
          x_d = {x_d[7:0], x_d[15:8]};
          y_d = {y_d[7:0], y_d[15:8]};
        end
      end
      swpd_pkg::KIND_CFG_FLD: begin
        raw_d = msb_first_i ? q_rec_i.word : rev_bytes(q_rec_i.word, q_rec_i.nbytes);
      end
      default: begin
        raw_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= q_rec_i.kind;
      index_q <= q_rec_i.index;
      raw_q   <= raw_d;
      x_q     <= x_d;
      y_q     <= y_d;
      pkind_q <= pkind_d;
      count_q <= q_rec_i.count;
      last_q  <= q_rec_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign field_index_o = index_q;
  assign raw_word_o    = raw_q;
  assign point_x_o     = x_q;
  assign point_y_o     = y_q;
  assign point_kind_o  = pkind_q;
  assign point_count_o = count_q;
  assign last_o        = last_q;

  // a course point never carries a zero point count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == swpd_pkg::KIND_POINT |-> point_count_o != 8'd0)
    else $error("course point with zero count");

endmodule

/* sim/sync_word_packet_deframer_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for sync_word_packet_deframer: byte stream in, parsed results out.
// Keeps its own parser model and register mirror; needs swpd_pkg and the deframer RTL.
module sync_word_packet_deframer_tb;

  localparam int TOTAL_BYTES      = 650;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT      = 4000;
  localparam int SETTLE_CYCLES    = 6;
  localparam int MAX_REPORTS      = 10;
  localparam logic [31:0] SYNC_MASK = {32{1'b1}} >> (32 - swpd_pkg::SyncBits);

  typedef enum logic [2:0] {
    PH_HUNT, PH_TYPE, PH_SEQ, PH_CMD, PH_LEN, PH_POINTS, PH_CFG
  } parse_phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  index;
    logic [63:0] word;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  ptype;
    logic [7:0]  count;
    logic        last;
  } parsed_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = swpd_pkg::REG_SYNC_WORD;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         kind_o;
  logic [7:0]         field_index_o;
  logic [63:0]        raw_word_o;
  logic signed [15:0] point_x_o;
  logic signed [15:0] point_y_o;
  logic [7:0]         point_kind_o;
  logic [7:0]         point_count_o;
  logic               last_o;

  sync_word_packet_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .field_index_o (field_index_o),
    .raw_word_o    (raw_word_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_kind_o  (point_kind_o),
    .point_count_o (point_count_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser model state and register mirror
  parse_phase_e     ph;
  logic [31:0]      sync_win;
  int               win_fill;
  int               byte_cnt;
  logic [7:0]       fld_num;
  logic [7:0]       pts_total;
  logic [7:0]       type_byte;
  logic [63:0]      asm_bytes;
  swpd_pkg::cfg_t   regs_m;
  parsed_t          due_results[$];

  logic [7:0]   burst[$];
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  bit           sink_hold_req = 1'b0;
  int           errors = 0;
  int           bytes_sent = 0;
  int           reg_writes = 0;
  int           results_seen = 0;
  int           points_seen = 0;
  int           fields_seen = 0;
  int           quiet_cycles = 0;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch %0d at %0t: %s", errors, $time, msg);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void back_to_hunt();
    ph = PH_HUNT;
    sync_win = '0;
    win_fill = 0;
  endfunction

  function automatic void reset_model();
    regs_m.sync_word = 32'h0;
    regs_m.ack_code = 8'd0;
    regs_m.command_code_value = 8'd1;
    regs_m.course_code = 8'd2;
    regs_m.settings_code = 8'd3;
    regs_m.msb_first = 1'b1;
    back_to_hunt();
    byte_cnt = 0;
    fld_num = '0;
    pts_total = '0;
    type_byte = '0;
    asm_bytes = '0;
  endfunction

  function automatic int field_bytes(input logic [7:0] n);
    case (n)
      8'd0, 8'd1, 8'd3: return 8;
      8'd2: return 4;
      default: return 1;
    endcase
  endfunction

  // Bytes are held first-arrived-most-significant; reverse n of them for LSB-first links
  function automatic logic [63:0] as_value(input logic [63:0] v, input int n);
    logic [63:0] r;
    r = '0;
    if (regs_m.msb_first) return v;
    for (int i = 0; i < n; i++) begin
      r = {r[55:0], v[7:0]};
      v = v >> 8;
    end
    return r;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    parsed_t r;
    logic [63:0] w;
    int n;
    r = '0;
    case (ph)
      PH_HUNT: begin
        sync_win = {sync_win[23:0], b} & SYNC_MASK;
        if (win_fill < int'(swpd_pkg::SYNC_LEN)) win_fill++;
        if (win_fill >= int'(swpd_pkg::SYNC_LEN) &&
            sync_win == (regs_m.sync_word & SYNC_MASK)) begin
          sync_win = '0;
          win_fill = 0;
          ph = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_byte = b;
        ph = PH_SEQ;
      end
      PH_SEQ: begin
        byte_cnt = 0;
        fld_num = '0;
        asm_bytes = '0;
        // codes are tested in priority order: ack, command, course, config
        if (type_byte == regs_m.ack_code) begin
          r.kind = swpd_pkg::KIND_ACK;
          r.last = 1'b1;
          due_results.push_back(r);
          back_to_hunt();
        end else if (type_byte == regs_m.command_code_value) begin
          ph = PH_CMD;
        end else if (type_byte == regs_m.course_code) begin
          ph = PH_LEN;
        end else if (type_byte == regs_m.settings_code) begin
          ph = PH_CFG;
        end else begin
          back_to_hunt();
        end
      end
      PH_CMD: begin
        r.kind = swpd_pkg::KIND_CMD;
        r.word = {56'd0, b};
        r.last = 1'b1;
        due_results.push_back(r);
        back_to_hunt();
      end
      PH_LEN: begin
        pts_total = b;
        if (b == 8'd0) begin
          r.kind = swpd_pkg::KIND_EMPTY;
          r.last = 1'b1;
          due_results.push_back(r);
          back_to_hunt();
        end else begin
          fld_num = '0;
          byte_cnt = 0;
          asm_bytes = '0;
          ph = PH_POINTS;
        end
      end
      PH_POINTS: begin
        asm_bytes = {asm_bytes[55:0], b};
        byte_cnt++;
        if (byte_cnt == int'(swpd_pkg::PointBytes)) begin
          r.kind = swpd_pkg::KIND_POINT;
          r.index = fld_num;
          w = as_value({48'd0, asm_bytes[39:24]}, 2);
          r.x = w[15:0];
          w = as_value({48'd0, asm_bytes[23:8]}, 2);
          r.y = w[15:0];
          r.ptype = asm_bytes[7:0];
          r.count = pts_total;
          r.last = (fld_num == pts_total - 8'd1);
          due_results.push_back(r);
          byte_cnt = 0;
          asm_bytes = '0;
          if (r.last) back_to_hunt();
          else fld_num++;
        end
      end
      PH_CFG: begin
        n = field_bytes(fld_num);
        asm_bytes = {asm_bytes[55:0], b};
        byte_cnt++;
        if (byte_cnt == n) begin
          r.kind = swpd_pkg::KIND_CFG_FLD;
          r.index = fld_num;
          r.word = as_value(asm_bytes, n);
          r.last = (fld_num >= 8'(swpd_pkg::CfgFields - 1));
          due_results.push_back(r);
          byte_cnt = 0;
          asm_bytes = '0;
          if (r.last) back_to_hunt();
          else fld_num++;
        end
      end
      default: back_to_hunt();
    endcase
  endfunction

  // One beat on the byte channel; valid stays up only when another byte follows at once
  task automatic send_byte(input logic [7:0] b, input bit more);
    int gap;
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
    gap = tx_idle_en ? idle_len() : 0;
    // valid drops at the end of a burst
    if (!more && gap == 0) gap = 1;
    if (gap > 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_burst();
    for (int i = 0; i < burst.size(); i++) send_byte(burst[i], i < burst.size() - 1);
    burst.delete();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      swpd_pkg::REG_SYNC_WORD: regs_m.sync_word = data;
      swpd_pkg::REG_ACK_CODE:  regs_m.ack_code = data[7:0];
      swpd_pkg::REG_CMD_CODE:  regs_m.command_code_value = data[7:0];
      swpd_pkg::REG_CRS_CODE:  regs_m.course_code = data[7:0];
      swpd_pkg::REG_SET_CODE:  regs_m.settings_code = data[7:0];
      swpd_pkg::REG_MSB_FIRST: regs_m.msb_first = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Sender holds off until every pending result is out and the pipe is empty
  task automatic settle();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Unused upper bits of narrow registers get random junk
  function automatic logic [31:0] with_junk(input logic [31:0] v, input logic [31:0] keep);
    return ($urandom & ~keep) | (v & keep);
  endfunction

  task automatic apply_settings(input logic [31:0] sw, input logic [7:0] ack,
                                input logic [7:0] cmd, input logic [7:0] crs,
                                input logic [7:0] set, input logic msb);
    settle();
    write_reg(swpd_pkg::REG_SYNC_WORD, sw);
    write_reg(swpd_pkg::REG_ACK_CODE, with_junk({24'd0, ack}, 32'hFF));
    write_reg(swpd_pkg::REG_CMD_CODE, with_junk({24'd0, cmd}, 32'hFF));
    write_reg(swpd_pkg::REG_CRS_CODE, with_junk({24'd0, crs}, 32'hFF));
    write_reg(swpd_pkg::REG_SET_CODE, with_junk({24'd0, set}, 32'hFF));
    write_reg(swpd_pkg::REG_MSB_FIRST, with_junk({31'd0, msb}, 32'h1));
  endtask

  function automatic void add_sync();
    for (int i = int'(swpd_pkg::SYNC_LEN) - 1; i >= 0; i--)
      burst.push_back(regs_m.sync_word[8*i +: 8]);
  endfunction

  function automatic void add_header(input logic [7:0] t);
    add_sync();
    burst.push_back(t);
    burst.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed packets with random content; some line noise and cut-off packets
  function automatic void add_random_packet();
    int pick, start, cnt, cut;
    logic [7:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) t = regs_m.ack_code;
    else if (pick < 35) t = regs_m.command_code_value;
    else if (pick < 65) t = regs_m.course_code;
    else if (pick < 88) t = regs_m.settings_code;
    else t = 8'($urandom_range(0, 255));
    start = burst.size();
    add_header(t);
    if (t == regs_m.ack_code) begin
    end else if (t == regs_m.command_code_value) begin
      burst.push_back(8'($urandom_range(0, 255)));
    end else if (t == regs_m.course_code) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) cnt = $urandom_range(0, 3);
      else if (pick < 95) cnt = $urandom_range(4, 10);
      else cnt = $urandom_range(11, 40);
      burst.push_back(8'(cnt));
      repeat (5 * cnt) burst.push_back(8'($urandom_range(0, 255)));
    end else if (t == regs_m.settings_code) begin
      repeat (30) burst.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 6) begin
      cut = $urandom_range(1, burst.size() - start - 1);
      repeat (cut) void'(burst.pop_back());
    end
  endfunction

  task automatic test_reset_defaults();
    // reset values: sync word all zero, ack 0, command 1, MSB first
    add_header(regs_m.ack_code);
    add_header(regs_m.command_code_value);
    burst.push_back(8'hFF);
    add_header(regs_m.command_code_value);
    burst.push_back(8'h00);
    send_burst();
    settle();
  endtask

  task automatic test_code_priority();
    write_reg(swpd_pkg::REG_SYNC_WORD, 32'hA5C3_0F96);
    write_reg(swpd_pkg::REG_ACK_CODE, 32'h5A);
    write_reg(swpd_pkg::REG_CMD_CODE, 32'h5A);
    write_reg(swpd_pkg::REG_CRS_CODE, 32'h5A);
    write_reg(swpd_pkg::REG_SET_CODE, 32'h5A);
    write_reg(swpd_pkg::REG_MSB_FIRST, 32'h1);
    add_header(8'h5A);
    send_burst();
    settle();
    write_reg(swpd_pkg::REG_ACK_CODE, 32'h11);
    add_header(8'h5A);
    burst.push_back(8'h7E);
    send_burst();
    settle();
    write_reg(swpd_pkg::REG_CMD_CODE, 32'h22);
    add_header(8'h5A);
    burst.push_back(8'h00);
    send_burst();
    settle();
    // unknown type eats its sequence byte, then hunting resumes
    write_reg(swpd_pkg::REG_CRS_CODE, 32'h33);
    add_header(8'h44);
    add_header(8'h11);
    send_burst();
    settle();
  endtask

  task automatic test_midpacket_change();
    // byte order flips after the sequence byte, before the count and point bytes
    add_header(8'h33);
    send_burst();
    settle();
    write_reg(swpd_pkg::REG_MSB_FIRST, 32'h0);
    burst.push_back(8'h01);
    burst.push_back(8'h80);
    burst.push_back(8'h00);
    burst.push_back(8'h7F);
    burst.push_back(8'hFF);
    burst.push_back(8'hC3);
    send_burst();
    settle();
    // type decode uses the codes in force when the sequence byte lands
    add_sync();
    burst.push_back(8'h66);
    send_burst();
    settle();
    write_reg(swpd_pkg::REG_CMD_CODE, 32'h66);
    burst.push_back(8'h09);
    burst.push_back(8'hA5);
    send_burst();
    settle();
  endtask

  task automatic test_backpressure();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    sink_hold_req = 1'b1;
    repeat (12) add_header(regs_m.ack_code);
    send_burst();
    settle();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 1'b0);
        1: apply_settings(32'h0000_0000, 8'h00, 8'h01, 8'h02, 8'h03, 1'b1);
        default: apply_settings($urandom, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
      tx_idle_en = (p != 1);
      rx_idle_en = (p != 1);
      target = bytes_sent + (TOTAL_BYTES - bytes_sent) / (6 - p);
      while (bytes_sent < target) begin
        add_random_packet();
        send_burst();
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Result side ready: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (n = 0; n < SINK_HOLD_CYCLES; n++) @(posedge clk_i);
      end else begin
        n = rx_idle_en ? idle_len() : 0;
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  always @(posedge clk_i) begin : result_check
    parsed_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (kind_o == swpd_pkg::KIND_POINT) points_seen++;
      if (kind_o == swpd_pkg::KIND_CFG_FLD) fields_seen++;
      if (due_results.size() == 0) begin
        flag_error($sformatf("result beat kind %0d expected none", kind_o));
      end else begin
        want = due_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind_o));
        check_field("field_index", 64'(want.index), 64'(field_index_o));
        check_field("raw_word", want.word, raw_word_o);
        check_field("point_x", 64'(want.x), 64'($unsigned(point_x_o)));
        check_field("point_y", 64'(want.y), 64'($unsigned(point_y_o)));
        check_field("point_kind", 64'(want.ptype), 64'(point_kind_o));
        check_field("point_count", 64'(want.count), 64'(point_count_o));
        check_field("last", 64'(want.last), 64'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_code_priority();
    test_midpacket_change();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk_i);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never came out", due_results.size()));
    $display("Covered %0d bytes and %0d register writes over reset, priority, mid-packet,",
             bytes_sent, reg_writes);
    $display("stall and random phases; %0d results checked (%0d points, %0d config fields).",
             results_seen, points_seen, fields_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
